// File: rtl/definite_length_block_parser_core_defines.svh
// Assertion macros for the block parser core.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef DEFINITE_LENGTH_BLOCK_PARSER_CORE_DEFINES_SVH
`define DEFINITE_LENGTH_BLOCK_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define DLBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlbp: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define DLBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlbp: next-cycle check failed");

`endif

// File: rtl/dlbp_pkg.sv
// Shared types and constants for the definite-length block parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dlbp_pkg;

	localparam int MAX_LEN_DIGITS = 9;
	localparam int DIGITS_W = $clog2(MAX_LEN_DIGITS + 1);
	localparam int BYTES_W = 30;
	localparam int TOTAL_W = 32;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CNT_MAX = CH_ZERO + 8'(MAX_LEN_DIGITS);

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_COUNT = 2'd1,
		PH_LEN = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_PREFIX = 2'd0,
		ERR_COUNT = 2'd1,
		ERR_LEN = 2'd2
	} err_t;

	typedef struct packed {
		phase_t phase;
		logic [DIGITS_W-1:0] digits_left;
		logic [BYTES_W-1:0] bytes_left;
		logic [TOTAL_W-1:0] total_count;
	} state_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
		logic [7:0] data_byte;
		logic block_last;
		logic [TOTAL_W-1:0] total_bytes;
		err_t error_code;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/dlbp_step.sv
// Per-byte deframing step: next parser state and the result of one byte.
// Depends on dlbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlbp_step import dlbp_pkg::*; (
	input wire logic [7:0] rx_byte,
	input wire state_t cur,
	output state_t nxt,
	output res_t res
);

	logic [7:0] digit_val;
	logic is_digit;
	logic cnt_ok;
	logic [BYTES_W+2:0] acc_wide;
	logic [BYTES_W-1:0] acc;
	logic [DIGITS_W-1:0] digits_dec;
	logic [BYTES_W-1:0] bytes_dec;
	logic [TOTAL_W-1:0] total_inc;

	assign digit_val = rx_byte - CH_ZERO;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign cnt_ok = (rx_byte > CH_ZERO) && (rx_byte <= CH_CNT_MAX);
	// x*10 as two shifts and an add
	assign acc_wide = {cur.bytes_left, 3'b000} + {2'b00, cur.bytes_left, 1'b0}
		+ {{(BYTES_W-5){1'b0}}, digit_val};
	assign acc = acc_wide[BYTES_W-1:0];
	assign digits_dec = cur.digits_left - DIGITS_W'(1);
	assign bytes_dec = cur.bytes_left - BYTES_W'(1);
	assign total_inc = (&cur.total_count) ? cur.total_count
		: cur.total_count + TOTAL_W'(1);

	// next state
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_COUNT: begin
				if (cnt_ok) begin
					nxt.phase = PH_LEN;
					nxt.digits_left = digit_val[DIGITS_W-1:0];
					nxt.bytes_left = '0;
				end else begin
					nxt = '0;
				end
			end
			PH_LEN: begin
				if (!is_digit) begin
					nxt = '0;
				end else begin
					nxt.bytes_left = acc;
					nxt.digits_left = digits_dec;
					if (digits_dec == '0) begin
						nxt.phase = (acc == '0) ? PH_PREFIX : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				nxt.total_count = total_inc;
				nxt.bytes_left = bytes_dec;
				if (bytes_dec == '0) begin
					nxt.phase = PH_PREFIX;
				end
			end
			PH_PREFIX: begin
				if (rx_byte == CH_HASH) begin
					nxt.phase = PH_COUNT;
				end else begin
					nxt = '0;
				end
			end
		endcase
	end

	// result
	always_comb begin
		res = '0;
		unique case (cur.phase)
			PH_COUNT: begin
				if (!cnt_ok) begin
					res.valid = 1'b1;
					res.kind = KIND_ERR;
					res.error_code = ERR_COUNT;
				end
			end
			PH_LEN: begin
				if (!is_digit) begin
					res.valid = 1'b1;
					res.kind = KIND_ERR;
					res.error_code = ERR_LEN;
				end
			end
			PH_DATA: begin
				res.valid = 1'b1;
				res.kind = KIND_DATA;
				res.data_byte = rx_byte;
				res.block_last = (bytes_dec == '0);
				res.total_bytes = total_inc;
			end
			PH_PREFIX: begin
				if (rx_byte == CH_NL) begin
					res.valid = 1'b1;
					res.kind = KIND_END;
					res.total_bytes = cur.total_count;
				end else if (rx_byte != CH_HASH) begin
					res.valid = 1'b1;
					res.kind = KIND_ERR;
					res.error_code = ERR_PREFIX;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/definite_length_block_parser_core.sv
// Definite-length block deframer. One received byte per beat goes in; payload bytes
// with a last-of-block flag, message-end totals and framing errors come out. A
// message is a chain of blocks ('#', digit count N, N length digits, payload)
// closed by a newline. Throughput is one byte per cycle unless the output stalls:
// each byte is decoded in the cycle it is accepted and any result lands in a single
// output register, so results appear in the cycle after acceptance. Valid header
// bytes produce no result. The output register is the only buffering: input ready
// is high whenever that register is empty or being drained in the same cycle.
// Depends on dlbp_pkg, dlbp_step and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "definite_length_block_parser_core_defines.svh"
module definite_length_block_parser_core import dlbp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic block_last,
	output logic [31:0] total_bytes,
	output logic [1:0] error_code
);

	state_t st_q;
	state_t st_nxt;
	res_t step_res;
	logic in_acc;
	logic load_res;

	logic out_valid_q;
	kind_t kind_q;
	logic [7:0] data_byte_q;
	logic block_last_q;
	logic [TOTAL_W-1:0] total_bytes_q;
	err_t error_code_q;

	// decode of the current byte against parser state
	dlbp_step u_step (
		.rx_byte (rx_byte),
		.cur (st_q),
		.nxt (st_nxt),
		.res (step_res)
	);

	// output register frees up when empty or being taken this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;
	assign load_res = in_acc && step_res.valid;

	// parser state advances on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_res) begin
			kind_q <= step_res.kind;
			data_byte_q <= step_res.data_byte;
			block_last_q <= step_res.block_last;
			total_bytes_q <= step_res.total_bytes;
			error_code_q <= step_res.error_code;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign data_byte = data_byte_q;
	assign block_last = block_last_q;
	assign total_bytes = total_bytes_q;
	assign error_code = error_code_q;

	// checks
	`DLBP_ASSERT_IMP(a_len_has_digits, st_q.phase == PH_LEN, st_q.digits_left != '0)
	`DLBP_ASSERT_IMP(a_data_has_bytes, st_q.phase == PH_DATA, st_q.bytes_left != '0)
	`DLBP_ASSERT_NXT(a_end_err_idle, load_res && step_res.kind != KIND_DATA,
		st_q.phase == PH_PREFIX && st_q.total_count == '0)
	`DLBP_ASSERT_IMP(a_nondata_clean, out_valid && kind != KIND_DATA,
		data_byte == 8'h00 && block_last == 1'b0)

endmodule
`default_nettype wire
